@@ hw/rtl/painless_gabor_dual_window_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the painless Gabor dual window unit
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PAINLESS_GABOR_DUAL_WINDOW_UNIT_MACROS_SVH
`define PAINLESS_GABOR_DUAL_WINDOW_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PGDW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PGDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PGDW_ASSERT(lbl, clk, rst_n, prop, msg)
`define PGDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/pgdw_pkg.sv @@
// ----------------------------------------------------------------------------
// pgdw_pkg
// Types, codes and sizes shared by the painless Gabor dual window unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pgdw_pkg;
	localparam int MAX_LEN     = 4096;
	localparam int MAX_HOP     = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int HOP_AW      = 10;
	localparam int DIAG_W      = 48;
	localparam int LEN_W       = 13;
	localparam int HOP_W       = 11;
	localparam int CHAN_W      = 16;
	localparam int POS_W       = 12;
	localparam int CFG_W       = 16;

	localparam logic [1:0] MODE_ACC   = 2'd0;
	localparam logic [1:0] MODE_APPLY = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [1:0] KIND_DUAL  = 2'd0;
	localparam logic [1:0] KIND_TIGHT = 2'd1;
	localparam logic [1:0] KIND_PU    = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFRAME  = 2'd1;
	localparam logic [1:0] ST_NOPAIN   = 2'd2;
	localparam logic [1:0] ST_ZERODIAG = 2'd3;

	localparam logic [1:0] CFG_LEN  = 2'd0;
	localparam logic [1:0] CFG_HOP  = 2'd1;
	localparam logic [1:0] CFG_CHAN = 2'd2;
	localparam logic [1:0] CFG_KIND = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PHASE, S_PHFIN, S_READ, S_ACC, S_MUL, S_SUM,
		S_CHK, S_NORM, S_SQRT, S_DIV, S_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [6:0]  steps;
		logic [63:0] den;
		logic [31:0] lim;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
	} div_rsp_t;
endpackage

@@ hw/rtl/pgdw_if.sv @@
// ----------------------------------------------------------------------------
// pgdw channel interfaces
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface pgdw_in_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               mode;
	logic signed [15:0]       sample;
	logic [11:0]              position;
	modport source (output valid, mode, sample, position, input ready);
	modport sink (input valid, mode, sample, position, output ready);
endinterface

interface pgdw_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [1:0]         status;
	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

@@ hw/rtl/pgdw_div.sv @@
// ----------------------------------------------------------------------------
// pgdw_div
// Bit-serial restoring divider, one quotient bit a cycle, saturating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pgdw_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pgdw_pkg::div_req_t req,
	output pgdw_pkg::div_rsp_t rsp
);
	logic        busy_q;
	logic        done_q;
	logic        sat_q;
	logic [6:0]  cnt_q;
	logic [6:0]  steps_q;
	logic [31:0] num_q;
	logic [63:0] den_q;
	logic [31:0] lim_q;
	logic [63:0] rem_q;
	logic [32:0] quot_q;

	logic        bit_in;
	logic [64:0] rr;
	logic        take;
	logic [32:0] q_nx;
	logic        over;
	logic        last;

	always_comb begin
		bit_in = (cnt_q < 7'd32) ? num_q[~cnt_q[4:0]] : 1'b0;
		rr     = {rem_q, bit_in};
		take   = (rr >= {1'b0, den_q});
		q_nx   = {quot_q[31:0], take};
		over   = (q_nx > {1'b0, lim_q});
		last   = (cnt_q == steps_q - 7'd1) || over;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				sat_q  <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (over)
					sat_q <= 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q   <= req.num;
			den_q   <= req.den;
			lim_q   <= req.lim;
			steps_q <= req.steps;
			rem_q   <= '0;
			quot_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= take ? (rr[63:0] - den_q) : rr[63:0];
			quot_q <= q_nx;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sat_q ? lim_q : quot_q[31:0];
endmodule

@@ hw/rtl/painless_gabor_dual_window_unit.sv @@
// ----------------------------------------------------------------------------
// painless_gabor_dual_window_unit
// Painless Gabor dual, tight and partition-of-unity window computation.
// ----------------------------------------------------------------------------
// channel  dir  payload                   handshake
// in_ch    in   mode, sample, position    valid/ready
// out_ch   out  value, status             valid/ready
// cfg      in   cfg_idx, cfg_data         cfg_we, no wait
//
// After reset and after a clear beat the diagonal store is swept,
// one entry a cycle; no beat is taken meanwhile.
// Accumulate: 13-step phase modulo, fix-up, read and write, then the next beat.
// Apply: the same phase steps, then multiply, sum, check and the divider, 48 steps
// for partition of unity, 63 for dual; tight adds a normalize loop, 32 square-root
// steps and e more divider steps (e up to 31). Saturation ends the shared divider early.
// A stalled result holds in the output register; the next beat is taken then.
`timescale 1ns / 1ps
`include "painless_gabor_dual_window_unit_macros.svh"
module painless_gabor_dual_window_unit (
	input  logic              clk,
	input  logic              arst_n,
	pgdw_in_if.sink           in_ch,
	pgdw_out_if.source        out_ch,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [15:0]       cfg_data
);
	pgdw_pkg::state_t state_q, state_d;

	logic [12:0] len_q;
	logic [10:0] hop_q;
	logic [15:0] chan_q;
	logic [1:0]  kind_q;

	logic [1:0]  mode_q;
	logic        neg_q;
	logic [15:0] mag_q;
	logic [30:0] sq_q;
	logic [10:0] clr_cnt_q;
	logic [12:0] mx_q;
	logic [12:0] mr_q;
	logic [3:0]  mcnt_q;
	logic        mflip_q;
	logic [9:0]  phase_q;
	logic [47:0] rdata_q;
	logic [39:0] pp_lo_s1;
	logic [39:0] pp_hi_s1;
	logic [63:0] d_q;
	logic [4:0]  e_q;
	logic [63:0] x_q;
	logic [63:0] res_q;
	logic [63:0] one_q;
	logic [4:0]  sq_cnt_q;
	logic [1:0]  st_q;
	logic        out_vld_q;
	logic [31:0] out_val_q;
	logic [1:0]  out_st_q;

	logic [47:0] mem_q [pgdw_pkg::MAX_HOP];

	pgdw_pkg::div_req_t div_req_q;
	pgdw_pkg::div_rsp_t div_rsp;

	logic        acc;
	logic        hop_bad;
	logic [1:0]  chk_st;
	logic [15:0] in_mag;
	logic [12:0] half;
	logic [12:0] pos_ext;
	logic [12:0] mrr;
	logic [12:0] mr_nx;
	logic [48:0] acc_sum;
	logic [63:0] sqt;
	logic        out_load;
	logic [31:0] res_val;

	pgdw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	always_comb begin
		acc     = in_ch.valid && in_ch.ready;
		hop_bad = (hop_q == '0) || (hop_q > 11'(pgdw_pkg::MAX_HOP));
		if ((len_q == '0) || hop_bad || (chan_q == '0) || (len_q > 13'(pgdw_pkg::MAX_LEN)))
			chk_st = pgdw_pkg::ST_NOFRAME;
		else if (!((chan_q > {5'd0, hop_q}) && (len_q >= {2'd0, hop_q})))
			chk_st = pgdw_pkg::ST_NOFRAME;
		else if (chan_q < {3'd0, len_q})
			chk_st = pgdw_pkg::ST_NOPAIN;
		else
			chk_st = pgdw_pkg::ST_OK;
		in_mag  = in_ch.sample[15] ? (16'd0 - in_ch.sample) : in_ch.sample;
		half    = len_q - {1'b0, len_q[12:1]};
		pos_ext = {1'b0, in_ch.position};
		mrr     = {mr_q[11:0], mx_q[mcnt_q]};
		mr_nx   = (mrr >= {2'd0, hop_q}) ? (mrr - {2'd0, hop_q}) : mrr;
		acc_sum = {1'b0, rdata_q} + {18'd0, sq_q};
		sqt     = res_q + one_q;
		res_val = (neg_q && (kind_q != pgdw_pkg::KIND_PU)) ?
			(32'd0 - div_rsp.quot) : div_rsp.quot;
		out_load = (state_q == pgdw_pkg::S_OUT) && (!out_vld_q || out_ch.ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pgdw_pkg::S_CLEAR: if (clr_cnt_q == 11'(pgdw_pkg::MAX_HOP - 1)) state_d = pgdw_pkg::S_IDLE;
			pgdw_pkg::S_IDLE: begin
				if (acc) begin
					unique case (in_ch.mode)
						pgdw_pkg::MODE_CLEAR: state_d = pgdw_pkg::S_CLEAR;
						pgdw_pkg::MODE_ACC: state_d = hop_bad ? pgdw_pkg::S_IDLE : pgdw_pkg::S_PHASE;
						pgdw_pkg::MODE_APPLY: state_d = (chk_st != pgdw_pkg::ST_OK) ?
							pgdw_pkg::S_OUT : pgdw_pkg::S_PHASE;
						default: state_d = pgdw_pkg::S_IDLE;
					endcase
				end
			end
			pgdw_pkg::S_PHASE: if (mcnt_q == '0) state_d = pgdw_pkg::S_PHFIN;
			pgdw_pkg::S_PHFIN: state_d = pgdw_pkg::S_READ;
			pgdw_pkg::S_READ: state_d = (mode_q == pgdw_pkg::MODE_ACC) ? pgdw_pkg::S_ACC : pgdw_pkg::S_MUL;
			pgdw_pkg::S_ACC: state_d = pgdw_pkg::S_IDLE;
			pgdw_pkg::S_MUL: state_d = pgdw_pkg::S_SUM;
			pgdw_pkg::S_SUM: state_d = pgdw_pkg::S_CHK;
			pgdw_pkg::S_CHK: begin
				if (d_q == '0) state_d = pgdw_pkg::S_OUT;
				else if (kind_q == pgdw_pkg::KIND_TIGHT) state_d = pgdw_pkg::S_NORM;
				else state_d = pgdw_pkg::S_DIV;
			end
			pgdw_pkg::S_NORM: if (d_q[63:62] != 2'b00) state_d = pgdw_pkg::S_SQRT;
			pgdw_pkg::S_SQRT: if (sq_cnt_q == '0 && one_q != '0 && one_q[0]) state_d = pgdw_pkg::S_DIV;
			pgdw_pkg::S_DIV: if (div_rsp.done) state_d = pgdw_pkg::S_OUT;
			pgdw_pkg::S_OUT: if (out_load) state_d = pgdw_pkg::S_IDLE;
			default: state_d = pgdw_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready   = (state_q == pgdw_pkg::S_IDLE);
		out_ch.valid  = out_vld_q;
		out_ch.value  = out_val_q;
		out_ch.status = out_st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pgdw_pkg::S_CLEAR;
			clr_cnt_q <= '0;
			out_vld_q <= 1'b0;
			len_q     <= 13'd16;
			hop_q     <= 11'd4;
			chan_q    <= 16'd16;
			kind_q    <= pgdw_pkg::KIND_DUAL;
			div_req_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pgdw_pkg::S_CLEAR)
				clr_cnt_q <= clr_cnt_q + 11'd1;
			else
				clr_cnt_q <= '0;
			if (out_load)
				out_vld_q <= 1'b1;
			else if (out_ch.ready)
				out_vld_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					pgdw_pkg::CFG_LEN: len_q <= cfg_data[12:0];
					pgdw_pkg::CFG_HOP: hop_q <= cfg_data[10:0];
					pgdw_pkg::CFG_CHAN: chan_q <= cfg_data;
					pgdw_pkg::CFG_KIND: kind_q <= cfg_data[1:0];
					default: ;
				endcase
			end
			div_req_q.start <= 1'b0;
			if (state_q == pgdw_pkg::S_CHK && d_q != '0 && kind_q != pgdw_pkg::KIND_TIGHT) begin
				div_req_q.start <= 1'b1;
				div_req_q.den   <= d_q;
				if (kind_q == pgdw_pkg::KIND_PU) begin
					div_req_q.num   <= {1'b0, sq_q};
					div_req_q.steps <= 7'd48;
					div_req_q.lim   <= 32'h7FFF_FFFF;
				end else begin
					div_req_q.num   <= {16'd0, mag_q};
					div_req_q.steps <= 7'd63;
					div_req_q.lim   <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
				end
			end else if (state_q == pgdw_pkg::S_SQRT && state_d == pgdw_pkg::S_DIV) begin
				div_req_q.start <= 1'b1;
				div_req_q.den   <= (x_q >= sqt) ? ({1'b0, res_q[63:1]} + one_q) : {1'b0, res_q[63:1]};
				div_req_q.num   <= {16'd0, mag_q};
				div_req_q.steps <= 7'd48 + {2'd0, e_q};
				div_req_q.lim   <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q <= in_ch.mode;
			neg_q  <= in_ch.sample[15];
			mag_q  <= in_mag;
			sq_q   <= 31'(in_mag * in_mag);
			st_q   <= chk_st;
			mr_q   <= '0;
			mcnt_q <= 4'd12;
			if (pos_ext < half) begin
				mx_q    <= pos_ext;
				mflip_q <= 1'b0;
			end else if (pos_ext >= len_q) begin
				mx_q    <= pos_ext - len_q;
				mflip_q <= 1'b0;
			end else begin
				mx_q    <= len_q - pos_ext;
				mflip_q <= 1'b1;
			end
		end
		if (state_q == pgdw_pkg::S_PHASE) begin
			mr_q   <= mr_nx;
			mcnt_q <= mcnt_q - 4'd1;
		end
		if (state_q == pgdw_pkg::S_PHFIN)
			phase_q <= (mflip_q && mr_q != '0) ? 10'({2'd0, hop_q} - mr_q) : mr_q[9:0];
		if (state_q == pgdw_pkg::S_READ)
			rdata_q <= mem_q[phase_q];
		if (state_q == pgdw_pkg::S_CLEAR)
			mem_q[clr_cnt_q[9:0]] <= '0;
		else if (state_q == pgdw_pkg::S_ACC)
			mem_q[phase_q] <= acc_sum[48] ? {48{1'b1}} : acc_sum[47:0];
		if (state_q == pgdw_pkg::S_MUL) begin
			pp_lo_s1 <= rdata_q[23:0] * chan_q;
			pp_hi_s1 <= rdata_q[47:24] * chan_q;
		end
		if (state_q == pgdw_pkg::S_SUM) begin
			d_q <= {24'd0, pp_lo_s1} + {pp_hi_s1, 24'd0};
			e_q <= '0;
		end
		if (state_q == pgdw_pkg::S_NORM) begin
			if (d_q[63:62] == 2'b00) begin
				d_q <= {d_q[61:0], 2'b00};
				e_q <= e_q + 5'd1;
			end else begin
				x_q      <= d_q;
				res_q    <= '0;
				one_q    <= 64'd1 << 62;
				sq_cnt_q <= 5'd31;
			end
		end
		if (state_q == pgdw_pkg::S_SQRT) begin
			if (x_q >= sqt) begin
				x_q   <= x_q - sqt;
				res_q <= {1'b0, res_q[63:1]} + one_q;
			end else begin
				res_q <= {1'b0, res_q[63:1]};
			end
			one_q    <= {2'b00, one_q[63:2]};
			sq_cnt_q <= sq_cnt_q - 5'd1;
		end
		if (out_load) begin
			if (st_q != pgdw_pkg::ST_OK) begin
				out_st_q  <= st_q;
				out_val_q <= '0;
			end else if (d_q == '0) begin
				out_st_q  <= pgdw_pkg::ST_ZERODIAG;
				out_val_q <= '0;
			end else begin
				out_st_q  <= pgdw_pkg::ST_OK;
				out_val_q <= res_val;
			end
		end
	end

	`PGDW_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, acc && (state_d != pgdw_pkg::S_IDLE), !in_ch.ready, "ready high after a beat")
	`PGDW_ASSERT(a_clear_blocks, clk, arst_n, (state_q == pgdw_pkg::S_CLEAR) |-> !in_ch.ready, "beat taken during clear sweep")
	`PGDW_ASSERT(a_result_from_out, clk, arst_n, $rose(out_vld_q) |-> $past(state_q == pgdw_pkg::S_OUT), "result without apply")
	`PGDW_ASSERT_NEXT(a_div_start, clk, arst_n, div_req_q.start, state_q == pgdw_pkg::S_DIV, "divider started outside divide")
endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the painless Gabor window unit against its own predictor: each
// accepted accumulate or clear beat updates a private diagonal store, an
// apply beat queues the expected value and status; each result beat is
// compared in order. Configurations sweep valid, non-frame and non-painless
// settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         HOLD_CYCLES = 3000;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         status;
	} window_result_t;

	class window_scoreboard;
		longint unsigned diag[pgdw_pkg::MAX_HOP];
		int unsigned     len_r, hop_r, chan_r, kind_r;
		window_result_t  pending[$];
		int              errors;
		int              results_seen;

		function void clear_diag();
			foreach (diag[i]) diag[i] = 0;
		endfunction

		function void reset_state();
			clear_diag();
			len_r = 16; hop_r = 4; chan_r = 16;
			kind_r = 32'(pgdw_pkg::KIND_DUAL);
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				pgdw_pkg::CFG_LEN:  len_r = {19'd0, data[12:0]};
				pgdw_pkg::CFG_HOP:  hop_r = {21'd0, data[10:0]};
				pgdw_pkg::CFG_CHAN: chan_r = {16'd0, data};
				default:            kind_r = {30'd0, data[1:0]};
			endcase
		endfunction

		function int unsigned phase_of(int unsigned p);
			int unsigned half, r;
			half = len_r - len_r / 2;
			if (p < half) return p % hop_r;
			if (p >= len_r) return (p - len_r) % hop_r;
			r = (len_r - p) % hop_r;
			return (r == 0) ? 0 : hop_r - r;
		endfunction

		function longint unsigned quot_sat(longint unsigned num, int k,
				longint unsigned den, longint unsigned lim);
			logic [63:0] r, q;
			logic        b, top;
			q = 0; r = 0;
			for (int i = 0; i < 64 + k; i++) begin
				b = (i < 64) ? num[63 - i] : 1'b0;
				top = r[63];
				r = {r[62:0], b};
				q = q << 1;
				if (top || r >= den) begin
					r = r - den;
					q[0] = 1'b1;
				end
				if (q > lim) return lim;
			end
			return q;
		endfunction

		function longint unsigned root_of(longint unsigned x);
			longint unsigned res, one;
			res = 0;
			one = 64'd1 << 62;
			while (one > x) one = one >> 2;
			while (one != 0) begin
				if (x >= res + one) begin
					x = x - (res + one);
					res = (res >> 1) + one;
				end else begin
					res = res >> 1;
				end
				one = one >> 2;
			end
			return res;
		endfunction

		function void note_beat(logic [1:0] mode, logic signed [15:0] sample,
				logic [11:0] position);
			window_result_t  exp_r;
			longint unsigned mag, sq, d, lim, q, dn;
			logic            neg;
			int unsigned     ph, e;
			neg = sample[15];
			mag = neg ? (64'd65536 - {48'd0, sample}) : {48'd0, sample};
			if (mode == pgdw_pkg::MODE_CLEAR) begin
				clear_diag();
				return;
			end
			if (mode == pgdw_pkg::MODE_ACC) begin
				if (hop_r == 0 || hop_r > pgdw_pkg::MAX_HOP) return;
				ph = phase_of({20'd0, position});
				sq = mag * mag;
				if (sq > ((64'd1 << 48) - 1) - diag[ph]) diag[ph] = (64'd1 << 48) - 1;
				else diag[ph] = diag[ph] + sq;
				return;
			end
			if (mode != pgdw_pkg::MODE_APPLY) return;
			exp_r.value = 0;
			exp_r.status = pgdw_pkg::ST_OK;
			if (len_r == 0 || hop_r == 0 || chan_r == 0 || hop_r > pgdw_pkg::MAX_HOP ||
					len_r > pgdw_pkg::MAX_LEN) begin
				exp_r.status = pgdw_pkg::ST_NOFRAME;
			end else if (!(chan_r > hop_r && len_r >= hop_r)) begin
				exp_r.status = pgdw_pkg::ST_NOFRAME;
			end else if (!(chan_r >= len_r)) begin
				exp_r.status = pgdw_pkg::ST_NOPAIN;
			end else begin
				ph = phase_of({20'd0, position});
				d = diag[ph] * longint'(chan_r);
				lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
				if (d == 0) begin
					exp_r.status = pgdw_pkg::ST_ZERODIAG;
				end else begin
					if (kind_r == pgdw_pkg::KIND_TIGHT) begin
						e = 0;
						dn = d;
						while (dn < (64'd1 << 62)) begin
							dn = dn << 2;
							e++;
						end
						q = quot_sat(mag, 16 + e, root_of(dn), lim);
					end else if (kind_r == pgdw_pkg::KIND_PU) begin
						q = quot_sat(mag * mag, 16, d, 64'h7FFF_FFFF);
						neg = 1'b0;
					end else begin
						q = quot_sat(mag, pgdw_pkg::SAMPLE_BITS - 1 + 16, d, lim);
					end
					exp_r.value = neg ? -q[31:0] : q[31:0];
				end
			end
			pending.push_back(exp_r);
		endfunction

		function void check_result(logic signed [31:0] value, logic [1:0] status);
			window_result_t exp_r;
			results_seen++;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected: value %0d status %0d",
					value, status);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (value !== exp_r.value) begin
				$error("value: expected %0d, got %0d", exp_r.value, value);
				errors++;
			end
			if (status !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, status);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_data;

	pgdw_in_if  in_ch();
	pgdw_out_if out_ch();

	painless_gabor_dual_window_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	window_scoreboard sb;
	int beats_sent;
	int send_idle_pct;
	int recv_idle_pct;
	logic hold_go;
	int hold_cnt;
	int phases_run;
	longint cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note_beat(in_ch.mode, in_ch.sample, in_ch.position);
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.value, out_ch.status);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	task automatic send_beat(logic [1:0] mode, logic signed [15:0] sample,
			logic [11:0] position);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.sample <= sample;
		in_ch.position <= position;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		beats_sent++;
		if (beats_sent == 200) begin
			send_idle_pct = 51;
			recv_idle_pct = 32;
		end else if (beats_sent == 400) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(5, 0))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'($urandom_range(255, 0));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_phase(int unsigned len, int unsigned hop_v, int unsigned chan,
			int unsigned kind, int n_apply);
		int unsigned span;
		drain();
		write_reg(pgdw_pkg::CFG_LEN, 16'(len));
		write_reg(pgdw_pkg::CFG_HOP, 16'(hop_v));
		write_reg(pgdw_pkg::CFG_CHAN, 16'(chan));
		write_reg(pgdw_pkg::CFG_KIND, 16'(kind));
		phases_run++;
		send_beat(pgdw_pkg::MODE_CLEAR, 16'($urandom), 12'($urandom));
		span = (len == 0) ? 1 : ((len > 4096) ? 4096 : len);
		if (span <= 48) begin
			for (int p = 0; p < span; p++)
				send_beat(pgdw_pkg::MODE_ACC, pick_sample(), 12'(p));
		end else begin
			for (int i = 0; i < 40; i++)
				send_beat(pgdw_pkg::MODE_ACC, pick_sample(),
					12'($urandom_range(span - 1, 0)));
		end
		for (int i = 0; i < n_apply; i++) begin
			case ($urandom_range(9, 0))
				0: send_beat(MODE_UNUSED, 16'($urandom), 12'($urandom));
				1: send_beat(pgdw_pkg::MODE_ACC, pick_sample(), 12'($urandom));
				2: send_beat(pgdw_pkg::MODE_APPLY, pick_sample(), 12'hFFF);
				default: send_beat(pgdw_pkg::MODE_APPLY, pick_sample(),
					12'($urandom_range((span + 8 > 4095) ? 4095 : span + 8, 0)));
			endcase
		end
	endtask

	initial begin
		int unsigned len, hop_v, chan;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = pgdw_pkg::CFG_LEN;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = pgdw_pkg::MODE_ACC;
		in_ch.sample = '0;
		in_ch.position = '0;
		hold_go = 1'b0;
		sb = new();
		sb.reset_state();
		beats_sent = 0;
		send_idle_pct = 32;
		recv_idle_pct = 51;
		phases_run = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: dual, length 16, hop 4, 16 channels
		send_beat(pgdw_pkg::MODE_ACC, 16'sh8000, 12'd0);
		send_beat(pgdw_pkg::MODE_ACC, 16'sh7FFF, 12'd1);
		send_beat(pgdw_pkg::MODE_ACC, 16'sh0001, 12'd2);
		send_beat(pgdw_pkg::MODE_ACC, 16'shFFFF, 12'd15);
		send_beat(pgdw_pkg::MODE_ACC, 16'sh4000, 12'd8);
		send_beat(pgdw_pkg::MODE_APPLY, 16'sh8000, 12'd0);
		send_beat(pgdw_pkg::MODE_APPLY, 16'sh7FFF, 12'd1);
		send_beat(pgdw_pkg::MODE_APPLY, 16'sh0001, 12'd2);
		send_beat(pgdw_pkg::MODE_APPLY, 16'shFFFF, 12'd3);
		send_beat(pgdw_pkg::MODE_APPLY, 16'sh7FFF, 12'hFFF);
		send_beat(pgdw_pkg::MODE_APPLY, 16'sh0000, 12'd9);
		send_beat(MODE_UNUSED, 16'sh7FFF, 12'hFFF);
		send_beat(pgdw_pkg::MODE_CLEAR, 16'sh0000, 12'd0);
		send_beat(pgdw_pkg::MODE_APPLY, 16'sh1234, 12'd5);

		// fill the result path while the receiver holds off
		send_beat(pgdw_pkg::MODE_ACC, 16'sh2000, 12'd6);
		hold_go <= 1'b1;
		for (int i = 0; i < 8; i++) send_beat(pgdw_pkg::MODE_APPLY, pick_sample(), 12'd6);

		run_phase(1024, 1024, 65535, pgdw_pkg::KIND_TIGHT, 12);
		run_phase(4096, 1, 4096, pgdw_pkg::KIND_PU, 12);
		run_phase(1, 1, 2, KIND_UNUSED, 8);
		run_phase(8191, 2047, 0, pgdw_pkg::KIND_DUAL, 4);
		run_phase(4096, 1024, 1024, pgdw_pkg::KIND_DUAL, 4);
		run_phase(8, 4, 4, pgdw_pkg::KIND_TIGHT, 4);
		run_phase(20, 4, 10, pgdw_pkg::KIND_PU, 4);

		while (beats_sent < 560) begin
			hop_v = $urandom_range(12, 1);
			len = $urandom_range(40, hop_v);
			chan = ($urandom_range(4, 0) == 0) ? 65535 : $urandom_range(300, len + hop_v);
			if ($urandom_range(9, 0) == 0) begin
				len = $urandom_range(8191, 0);
				hop_v = $urandom_range(2047, 0);
				chan = $urandom_range(65535, 0);
			end
			run_phase(len, hop_v, chan, $urandom_range(3, 0), $urandom_range(20, 8));
		end

		drain();
		$display("%0d input beats over %0d configurations, %0d results checked",
			beats_sent, phases_run, sb.results_seen);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors,
				sb.pending.size());
			$display("status: fail");
		end
		$finish;
	end
endmodule

@@ painless_gabor_dual_window_unit.f @@
+incdir+hw/rtl
hw/rtl/pgdw_pkg.sv
hw/rtl/pgdw_if.sv
hw/rtl/pgdw_div.sv
hw/rtl/painless_gabor_dual_window_unit.sv
tb/tb.sv
